>>> sv/ecal_pkg.sv
// Shared types and constants for the epoch millisecond to local calendar converter.
package ecal_pkg;

    localparam int unsigned EPOCH_W  = 64;
    localparam int unsigned TZ_W     = 12;
    localparam int unsigned APB_AW   = 3;
    localparam int unsigned APB_DW   = 32;

    localparam int unsigned SPLIT_STAGES = 5;
    localparam int unsigned BACK_STAGES  = 7;
    localparam int unsigned STAGES       = SPLIT_STAGES + BACK_STAGES + 2;

    localparam int unsigned DAYS_W      = 22;
    localparam int unsigned SOD_MS_W    = 27;
    localparam int unsigned DAY_SHIFT   = 10;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned YEAR_W      = 14;
    localparam int unsigned MONTH_W     = 4;
    localparam int unsigned DAY_W       = 5;
    localparam int unsigned HOUR_W      = 5;
    localparam int unsigned MIN_W       = 6;
    localparam int unsigned SEC_W       = 6;
    localparam int unsigned SLEEP_W     = 15;
    localparam int unsigned SLEEP_MIN_W = 11;

    localparam int unsigned MS_PER_MIN     = 60000;
    localparam int unsigned MAX_OFFSET_MIN = 1440;
    localparam int unsigned MIN_PER_DAY    = 24 * 60;
    localparam int unsigned SEC_PER_HOUR   = 3600;
    localparam int unsigned FIRST_YEAR     = 2020;
    localparam int unsigned SLEEP_DAY_MAX  = 24836;
    localparam int unsigned DAY_MS_SHR     = 86400 * 1000 / (1 << DAY_SHIFT);

    localparam logic [EPOCH_W-1:0] MS_FIRST_YEAR = 64'd1577836800000;
    localparam logic [EPOCH_W-1:0] MS_LIMIT      = 64'd253402300800000;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_RANGE    = 2'd2,
        ST_EARLY    = 2'd3
    } t_status;

    typedef struct packed {
        t_status               status;
        logic [DAYS_W-1:0]     days;
        logic [SOD_MS_W-1:0]   sod_ms;
    } t_split;

    typedef struct packed {
        t_status                 status;
        logic [HOUR_W-1:0]       hour;
        logic [MIN_W-1:0]        minute;
        logic [SEC_W-1:0]        second;
        logic [SLEEP_W-1:0]      sleep_num;
        logic                    sleep_ok;
        logic [SLEEP_MIN_W-1:0]  sleep_minute;
    } t_tod;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

endpackage

>>> sv/ecal_split.sv
// Offset addition, range status and split of local time into day number and ms of day.
module ecal_split (
    input  logic                                i_clk,
    input  logic [ecal_pkg::SPLIT_STAGES-1:0]   i_en,
    input  logic [ecal_pkg::EPOCH_W-1:0]        i_epoch,
    input  logic [ecal_pkg::TZ_W-1:0]           i_tz,
    output ecal_pkg::t_split                    o_split
);
    import ecal_pkg::*;

    localparam int unsigned LOCAL_W = EPOCH_W + 1;
    localparam int unsigned OFF_W   = 29;
    localparam int unsigned Q_W     = 48;
    localparam int unsigned HALF_W  = Q_W / 2;
    localparam int unsigned M_W     = 32;
    localparam int unsigned P_W     = HALF_W + M_W;
    localparam int unsigned FULL_W  = Q_W + M_W;
    localparam int unsigned REM_W   = 18;
    localparam int unsigned FRAC_W  = SOD_MS_W - DAY_SHIFT;

    localparam logic [63:0]          M_WIDE    = (64'd1 << Q_W) / 64'(DAY_MS_SHR);
    localparam logic [M_W-1:0]       M_DAY     = M_W'(M_WIDE);
    localparam logic [Q_W-1:0]       DIVISOR   = Q_W'(DAY_MS_SHR);
    localparam logic [REM_W-1:0]     DIV_REM   = REM_W'(DAY_MS_SHR);
    localparam logic signed [OFF_W-1:0] OFF_SCALE = OFF_W'(MS_PER_MIN);
    localparam logic signed [TZ_W-1:0]  TZ_MAX    = TZ_W'(MAX_OFFSET_MIN);
    localparam logic signed [TZ_W-1:0]  TZ_MIN    = -TZ_MAX;

    logic signed [TZ_W-1:0]    tz_s;
    logic signed [OFF_W-1:0]   off_ms;
    logic signed [LOCAL_W-1:0] sum;
    logic                      tz_bad;
    logic                      sum_ovf;

    logic [EPOCH_W-1:0]        r1_local;
    logic                      r1_bad;

    t_status                   n2_status;
    logic [Q_W-1:0]            y2;
    logic [P_W-1:0]            p_lo;
    logic [P_W-1:0]            p_hi;
    t_status                   r2_status;
    logic [Q_W-1:0]            r2_y;
    logic [DAY_SHIFT-1:0]      r2_low;
    logic [P_W-1:0]            r2_plo;
    logic [P_W-1:0]            r2_phi;

    logic [FULL_W-1:0]         full;
    t_status                   r3_status;
    logic [DAYS_W-1:0]         r3_q;
    logic [Q_W-1:0]            r3_y;
    logic [DAY_SHIFT-1:0]      r3_low;

    logic [Q_W-1:0]            prod4;
    logic [Q_W-1:0]            diff4;
    t_status                   r4_status;
    logic [DAYS_W-1:0]         r4_q;
    logic [REM_W-1:0]          r4_rem;
    logic [DAY_SHIFT-1:0]      r4_low;

    logic                      fix5;
    logic [REM_W-1:0]          rem5;
    t_split                    n5_split;
    t_split                    r5_split;

    assign tz_s    = signed'(i_tz);
    assign off_ms  = tz_s * OFF_SCALE;
    assign tz_bad  = (tz_s < TZ_MIN) || (tz_s > TZ_MAX);
    assign sum     = LOCAL_W'(signed'(i_epoch)) + LOCAL_W'(off_ms);
    assign sum_ovf = sum[LOCAL_W-1] ^ sum[LOCAL_W-2];

    always_comb begin
        if (r1_bad) begin
            n2_status = ST_OVERFLOW;
        end else if (r1_local[EPOCH_W-1] || (r1_local >= MS_LIMIT)) begin
            n2_status = ST_RANGE;
        end else if (r1_local < MS_FIRST_YEAR) begin
            n2_status = ST_EARLY;
        end else begin
            n2_status = ST_OK;
        end
    end

    assign y2   = r1_local[DAY_SHIFT +: Q_W];
    assign p_lo = y2[HALF_W-1:0] * M_DAY;
    assign p_hi = y2[Q_W-1:HALF_W] * M_DAY;

    assign full  = {r2_phi, HALF_W'(0)} + FULL_W'(r2_plo);

    assign prod4 = Q_W'(r3_q) * DIVISOR;
    assign diff4 = r3_y - prod4;

    assign fix5 = r4_rem >= DIV_REM;
    assign rem5 = fix5 ? (r4_rem - DIV_REM) : r4_rem;

    always_comb begin
        n5_split.status = r4_status;
        n5_split.days   = fix5 ? (r4_q + DAYS_W'(1)) : r4_q;
        n5_split.sod_ms = {rem5[FRAC_W-1:0], r4_low};
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_local <= sum[EPOCH_W-1:0];
            r1_bad   <= tz_bad | sum_ovf;
        end
        if (i_en[1]) begin
            r2_status <= n2_status;
            r2_y      <= y2;
            r2_low    <= r1_local[DAY_SHIFT-1:0];
            r2_plo    <= p_lo;
            r2_phi    <= p_hi;
        end
        if (i_en[2]) begin
            r3_status <= r2_status;
            r3_q      <= full[Q_W +: DAYS_W];
            r3_y      <= r2_y;
            r3_low    <= r2_low;
        end
        if (i_en[3]) begin
            r4_status <= r3_status;
            r4_q      <= r3_q;
            r4_rem    <= diff4[REM_W-1:0];
            r4_low    <= r3_low;
        end
        if (i_en[4]) begin
            r5_split <= n5_split;
        end
    end

    assign o_split = r5_split;

endmodule

>>> sv/ecal_civil.sv
// Day number to proleptic Gregorian year, month and day.
module ecal_civil (
    input  logic                               i_clk,
    input  logic [ecal_pkg::BACK_STAGES-1:0]   i_en,
    input  logic [ecal_pkg::DAYS_W-1:0]        i_days,
    output ecal_pkg::t_date                    o_date
);
    import ecal_pkg::*;

    localparam int unsigned ERA_W  = 5;
    localparam int unsigned DOE_W  = 18;
    localparam int unsigned YOE_W  = 9;
    localparam int unsigned DOY_W  = 9;
    localparam int unsigned MP_W   = 4;
    localparam int unsigned X6_W   = 11;
    localparam int unsigned A_W    = 7;
    localparam int unsigned B_W    = 3;
    localparam int unsigned C_W    = 2;

    localparam logic [63:0] ONE = 64'd1;

    localparam int unsigned K_ERA = 40;
    localparam int unsigned MW_ERA = 23;
    localparam logic [MW_ERA-1:0] M_ERA = MW_ERA'(((ONE << K_ERA) + 64'd146096) / 64'd146097);
    localparam int unsigned K_A = 29;
    localparam int unsigned MW_A = 19;
    localparam logic [MW_A-1:0] M_A = MW_A'(((ONE << K_A) + 64'd1459) / 64'd1460);
    localparam int unsigned K_B = 34;
    localparam int unsigned MW_B = 19;
    localparam logic [MW_B-1:0] M_B = MW_B'(((ONE << K_B) + 64'd36523) / 64'd36524);
    localparam int unsigned K_Y = 27;
    localparam int unsigned MW_Y = 19;
    localparam logic [MW_Y-1:0] M_Y = MW_Y'(((ONE << K_Y) + 64'd364) / 64'd365);
    localparam int unsigned K_C = 16;
    localparam int unsigned MW_C = 10;
    localparam logic [MW_C-1:0] M_C = MW_C'(((ONE << K_C) + 64'd99) / 64'd100);
    localparam int unsigned K_M = 19;
    localparam int unsigned MW_M = 12;
    localparam logic [MW_M-1:0] M_M = MW_M'(((ONE << K_M) + 64'd152) / 64'd153);

    localparam logic [DAYS_W-1:0] SHIFT_DAYS = DAYS_W'(719468);
    localparam logic [DAYS_W-1:0] ERA_DAYS   = DAYS_W'(146097);
    localparam logic [DOE_W-1:0]  LAST_DOE   = DOE_W'(146096);
    localparam logic [DOE_W-1:0]  YEAR_DAYS  = DOE_W'(365);
    localparam logic [YEAR_W-1:0] ERA_YEARS  = YEAR_W'(400);
    localparam logic [MP_W-1:0]   MP_JAN     = MP_W'(10);

    logic [DAYS_W-1:0]        z1;
    logic [DAYS_W+MW_ERA-1:0] era_p;
    logic [DAYS_W-1:0]        r1_z;
    logic [ERA_W-1:0]         r1_era;

    logic [DAYS_W-1:0]        doe2;
    logic [DOE_W-1:0]         r2_doe;
    logic [ERA_W-1:0]         r2_era;

    logic [DOE_W+MW_A-1:0]    a_p;
    logic [DOE_W+MW_B-1:0]    b_p;
    logic [DOE_W-1:0]         t3;
    logic [DOE_W-1:0]         r3_t;
    logic [DOE_W-1:0]         r3_doe;
    logic [ERA_W-1:0]         r3_era;

    logic [DOE_W+MW_Y-1:0]    y_p;
    logic [YOE_W-1:0]         r4_yoe;
    logic [DOE_W-1:0]         r4_doe;
    logic [ERA_W-1:0]         r4_era;

    logic [YOE_W+MW_C-1:0]    c_p;
    logic [DOE_W-1:0]         yday5;
    logic [DOE_W-1:0]         doy5;
    logic [DOY_W-1:0]         r5_doy;
    logic [YOE_W-1:0]         r5_yoe;
    logic [ERA_W-1:0]         r5_era;

    logic [X6_W-1:0]          x6;
    logic [X6_W+MW_M-1:0]     m_p;
    logic [MP_W-1:0]          r6_mp;
    logic [DOY_W-1:0]         r6_doy;
    logic [YOE_W-1:0]         r6_yoe;
    logic [ERA_W-1:0]         r6_era;

    logic [DOY_W-1:0]         base7;
    logic [DOY_W-1:0]         mday7;
    logic                     jan_feb7;
    t_date                    n7_date;
    t_date                    r7_date;

    assign z1    = i_days + SHIFT_DAYS;
    assign era_p = z1 * M_ERA;

    assign doe2  = r1_z - DAYS_W'(r1_era) * ERA_DAYS;

    assign a_p = r2_doe * M_A;
    assign b_p = r2_doe * M_B;
    assign t3  = r2_doe - DOE_W'(a_p[K_A +: A_W]) + DOE_W'(b_p[K_B +: B_W])
                 - DOE_W'(r2_doe == LAST_DOE);

    assign y_p = r3_t * M_Y;

    assign c_p   = r4_yoe * M_C;
    assign yday5 = DOE_W'(r4_yoe) * YEAR_DAYS + DOE_W'(r4_yoe >> 2)
                   - DOE_W'(c_p[K_C +: C_W]);
    assign doy5  = r4_doe - yday5;

    assign x6  = X6_W'(r5_doy) * X6_W'(5) + X6_W'(2);
    assign m_p = x6 * M_M;

    always_comb begin
        case (r6_mp)
            4'd0:    base7 = 9'd0;
            4'd1:    base7 = 9'd31;
            4'd2:    base7 = 9'd61;
            4'd3:    base7 = 9'd92;
            4'd4:    base7 = 9'd122;
            4'd5:    base7 = 9'd153;
            4'd6:    base7 = 9'd184;
            4'd7:    base7 = 9'd214;
            4'd8:    base7 = 9'd245;
            4'd9:    base7 = 9'd275;
            4'd10:   base7 = 9'd306;
            4'd11:   base7 = 9'd337;
            default: base7 = 9'd0;
        endcase
    end

    assign mday7    = r6_doy - base7 + DOY_W'(1);
    assign jan_feb7 = r6_mp >= MP_JAN;

    always_comb begin
        n7_date.day   = mday7[DAY_W-1:0];
        n7_date.month = jan_feb7 ? (r6_mp - MP_W'(9)) : (r6_mp + MP_W'(3));
        n7_date.year  = YEAR_W'(r6_yoe) + YEAR_W'(r6_era) * ERA_YEARS
                        + YEAR_W'(jan_feb7);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_z   <= z1;
            r1_era <= era_p[K_ERA +: ERA_W];
        end
        if (i_en[1]) begin
            r2_doe <= doe2[DOE_W-1:0];
            r2_era <= r1_era;
        end
        if (i_en[2]) begin
            r3_t   <= t3;
            r3_doe <= r2_doe;
            r3_era <= r2_era;
        end
        if (i_en[3]) begin
            r4_yoe <= y_p[K_Y +: YOE_W];
            r4_doe <= r3_doe;
            r4_era <= r3_era;
        end
        if (i_en[4]) begin
            r5_doy <= doy5[DOY_W-1:0];
            r5_yoe <= r4_yoe;
            r5_era <= r4_era;
        end
        if (i_en[5]) begin
            r6_mp  <= m_p[K_M +: MP_W];
            r6_doy <= r5_doy;
            r6_yoe <= r5_yoe;
            r6_era <= r5_era;
        end
        if (i_en[6]) begin
            r7_date <= n7_date;
        end
    end

    assign o_date = r7_date;

endmodule

>>> sv/ecal_tod.sv
// Time of day, sleep day and minutes since the sleep day's noon start.
module ecal_tod (
    input  logic                               i_clk,
    input  logic [ecal_pkg::BACK_STAGES-1:0]   i_en,
    input  ecal_pkg::t_split                   i_split,
    output ecal_pkg::t_tod                     o_tod
);
    import ecal_pkg::*;

    localparam int unsigned X1_W  = SOD_MS_W - 3;
    localparam int unsigned SOD_W = 17;
    localparam int unsigned REM_W = 12;

    localparam logic [63:0] ONE = 64'd1;

    localparam int unsigned K_SEC  = 31;
    localparam int unsigned MW_SEC = 25;
    localparam logic [MW_SEC-1:0] M_SEC = MW_SEC'(((ONE << K_SEC) + 64'd124) / 64'd125);
    localparam int unsigned K_HR  = 29;
    localparam int unsigned MW_HR = 18;
    localparam logic [MW_HR-1:0] M_HR = MW_HR'(((ONE << K_HR) + 64'd3599) / 64'd3600);
    localparam int unsigned K_MIN  = 18;
    localparam int unsigned MW_MIN = 13;
    localparam logic [MW_MIN-1:0] M_MIN = MW_MIN'(((ONE << K_MIN) + 64'd59) / 64'd60);

    localparam logic [SOD_W-1:0]       HOUR_SECS = SOD_W'(SEC_PER_HOUR);
    localparam logic [REM_W-1:0]       MIN_SECS  = REM_W'(60);
    localparam logic [SLEEP_MIN_W-1:0] HOUR_MINS = SLEEP_MIN_W'(60);
    localparam logic [HOUR_W-1:0]      NOON      = HOUR_W'(12);
    localparam logic [DAYS_W-1:0]      SLEEP_MAX = DAYS_W'(SLEEP_DAY_MAX);

    logic [X1_W+MW_SEC-1:0]   sec_p;
    logic [SOD_W-1:0]         r1_sod;
    logic [DAYS_W-1:0]        r1_days;
    t_status                  r1_status;

    logic [SOD_W+MW_HR-1:0]   hr_p;
    logic [HOUR_W-1:0]        r2_hr;
    logic [SOD_W-1:0]         r2_sod;
    logic [DAYS_W-1:0]        r2_days;
    t_status                  r2_status;

    logic [SOD_W-1:0]         rem3;
    logic [REM_W-1:0]         r3_rem;
    logic [HOUR_W-1:0]        r3_hr;
    logic [DAYS_W-1:0]        r3_days;
    t_status                  r3_status;

    logic [REM_W+MW_MIN-1:0]  min_p;
    logic [MIN_W-1:0]         r4_mi;
    logic [REM_W-1:0]         r4_rem;
    logic [HOUR_W-1:0]        r4_hr;
    logic [DAYS_W-1:0]        r4_days;
    t_status                  r4_status;

    logic                     pm5;
    logic [HOUR_W-1:0]        hr_adj5;
    logic [REM_W-1:0]         sec5;
    logic [DAYS_W-1:0]        sleep5;
    logic                     ok5;
    t_tod                     n5_tod;
    t_tod                     r5_tod;
    t_tod                     r6_tod;
    t_tod                     r7_tod;

    assign sec_p = i_split.sod_ms[SOD_MS_W-1:3] * M_SEC;
    assign hr_p  = r1_sod * M_HR;
    assign rem3  = r2_sod - SOD_W'(r2_hr) * HOUR_SECS;
    assign min_p = r3_rem * M_MIN;

    assign pm5     = r4_hr >= NOON;
    assign hr_adj5 = pm5 ? (r4_hr - NOON) : (r4_hr + NOON);
    assign sec5    = r4_rem - REM_W'(r4_mi) * MIN_SECS;
    assign sleep5  = pm5 ? r4_days : (r4_days - DAYS_W'(1));
    assign ok5     = sleep5 <= SLEEP_MAX;

    always_comb begin
        n5_tod.status       = r4_status;
        n5_tod.hour         = r4_hr;
        n5_tod.minute       = r4_mi;
        n5_tod.second       = sec5[SEC_W-1:0];
        n5_tod.sleep_num    = ok5 ? sleep5[SLEEP_W-1:0] : '0;
        n5_tod.sleep_ok     = ok5;
        n5_tod.sleep_minute = SLEEP_MIN_W'(hr_adj5) * HOUR_MINS + SLEEP_MIN_W'(r4_mi);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_sod    <= sec_p[K_SEC +: SOD_W];
            r1_days   <= i_split.days;
            r1_status <= i_split.status;
        end
        if (i_en[1]) begin
            r2_hr     <= hr_p[K_HR +: HOUR_W];
            r2_sod    <= r1_sod;
            r2_days   <= r1_days;
            r2_status <= r1_status;
        end
        if (i_en[2]) begin
            r3_rem    <= rem3[REM_W-1:0];
            r3_hr     <= r2_hr;
            r3_days   <= r2_days;
            r3_status <= r2_status;
        end
        if (i_en[3]) begin
            r4_mi     <= min_p[K_MIN +: MIN_W];
            r4_rem    <= r3_rem;
            r4_hr     <= r3_hr;
            r4_days   <= r3_days;
            r4_status <= r3_status;
        end
        if (i_en[4]) begin
            r5_tod <= n5_tod;
        end
        if (i_en[5]) begin
            r6_tod <= r5_tod;
        end
        if (i_en[6]) begin
            r7_tod <= r6_tod;
        end
    end

    assign o_tod = r7_tod;

endmodule

>>> sv/epoch_ms_to_local_calendar_unit.sv
// Top level: converts a Unix millisecond word to the local calendar date and time.
// Throughput: one word per cycle while the output is not stalled, through a 14-register
// pipeline (input register, twelve arithmetic stages, output register); stages with no
// word fill up under a stall.
// Reset clears every stage valid flag and sets the time-zone offset to zero.
module epoch_ms_to_local_calendar_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [ecal_pkg::EPOCH_W-1:0]        i_epoch_millis,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [ecal_pkg::STATUS_W-1:0]       o_status,
    output logic [ecal_pkg::YEAR_W-1:0]         o_year_out,
    output logic [ecal_pkg::MONTH_W-1:0]        o_month_out,
    output logic [ecal_pkg::DAY_W-1:0]          o_day_out,
    output logic [ecal_pkg::HOUR_W-1:0]         o_hour_out,
    output logic [ecal_pkg::MIN_W-1:0]          o_minute_out,
    output logic [ecal_pkg::SEC_W-1:0]          o_second_out,
    output logic [ecal_pkg::SLEEP_W-1:0]        o_sleep_day_number,
    output logic                                o_sleep_day_ok,
    output logic [ecal_pkg::SLEEP_MIN_W-1:0]    o_sleep_minute,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ecal_pkg::APB_AW-1:0]         paddr,
    input  logic [ecal_pkg::APB_DW-1:0]         pwdata,
    output logic [ecal_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);
    import ecal_pkg::*;

    localparam logic REG_TZ = 1'b0;
    localparam int unsigned BACK_LO = SPLIT_STAGES + 1;
    localparam int unsigned BACK_HI = SPLIT_STAGES + BACK_STAGES;

    logic [TZ_W-1:0]        r_tz;
    logic [STAGES-1:0]      r_valid;
    logic [STAGES-1:0]      n_valid;
    logic [STAGES-1:0]      en;
    logic [EPOCH_W-1:0]     r_epoch;
    logic                   tz_write;

    t_split                 split;
    t_tod                   tod;
    t_date                  date;

    t_status                r_status;
    logic [YEAR_W-1:0]      r_year;
    logic [MONTH_W-1:0]     r_month;
    logic [DAY_W-1:0]       r_day;
    logic [HOUR_W-1:0]      r_hour;
    logic [MIN_W-1:0]       r_minute;
    logic [SEC_W-1:0]       r_second;
    logic [SLEEP_W-1:0]     r_sleep_num;
    logic                   r_sleep_ok;
    logic [SLEEP_MIN_W-1:0] r_sleep_minute;

    genvar g;
    generate
        for (g = 0; g < STAGES; g++) begin : g_en
            assign en[g] = !((&r_valid[STAGES-1:g]) && i_stall);
        end
    endgenerate

    assign n_valid = {r_valid[STAGES-2:0], i_valid};
    assign o_stall = !en[0];
    assign o_valid = r_valid[STAGES-1];

    assign tz_write = psel && penable && pwrite && (paddr[APB_AW-1] == REG_TZ);
    assign prdata   = (paddr[APB_AW-1] == REG_TZ) ? APB_DW'(r_tz) : '0;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_tz    <= '0;
        end else begin
            r_valid <= (en & n_valid) | (~en & r_valid);
            if (tz_write) begin
                r_tz <= pwdata[TZ_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_epoch <= i_epoch_millis;
        end
    end

    ecal_split u_split (
        .i_clk   (i_clk),
        .i_en    (en[SPLIT_STAGES:1]),
        .i_epoch (r_epoch),
        .i_tz    (r_tz),
        .o_split (split)
    );

    ecal_civil u_civil (
        .i_clk  (i_clk),
        .i_en   (en[BACK_HI:BACK_LO]),
        .i_days (split.days),
        .o_date (date)
    );

    ecal_tod u_tod (
        .i_clk   (i_clk),
        .i_en    (en[BACK_HI:BACK_LO]),
        .i_split (split),
        .o_tod   (tod)
    );

    always_ff @(posedge i_clk) begin
        if (en[STAGES-1]) begin
            r_status <= tod.status;
            if (tod.status == ST_OK) begin
                r_year         <= date.year;
                r_month        <= date.month;
                r_day          <= date.day;
                r_hour         <= tod.hour;
                r_minute       <= tod.minute;
                r_second       <= tod.second;
                r_sleep_num    <= tod.sleep_num;
                r_sleep_ok     <= tod.sleep_ok;
                r_sleep_minute <= tod.sleep_minute;
            end else begin
                r_year         <= '0;
                r_month        <= '0;
                r_day          <= '0;
                r_hour         <= '0;
                r_minute       <= '0;
                r_second       <= '0;
                r_sleep_num    <= '0;
                r_sleep_ok     <= 1'b0;
                r_sleep_minute <= '0;
            end
        end
    end

    assign o_status           = r_status;
    assign o_year_out         = r_year;
    assign o_month_out        = r_month;
    assign o_day_out          = r_day;
    assign o_hour_out         = r_hour;
    assign o_minute_out       = r_minute;
    assign o_second_out       = r_second;
    assign o_sleep_day_number = r_sleep_num;
    assign o_sleep_day_ok     = r_sleep_ok;
    assign o_sleep_minute     = r_sleep_minute;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("Input stalled while the output word is not held.");

    a_error_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |->
            (o_year_out == '0 && o_month_out == '0 && o_day_out == '0 &&
             o_sleep_day_ok == 1'b0 && o_sleep_minute == '0))
        else $error("Error result word carries nonzero fields.");

    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_OK)) |->
            (o_year_out >= YEAR_W'(FIRST_YEAR) && o_month_out >= 4'd1 &&
             o_month_out <= 4'd12 && o_day_out >= 5'd1 && o_hour_out <= 5'd23 &&
             o_sleep_minute < SLEEP_MIN_W'(MIN_PER_DAY)))
        else $error("Valid result word has a field out of range.");

endmodule

>>> test/epoch_ms_to_local_calendar_unit_test.sv
// Self-checking testbench for the epoch millisecond to local calendar converter.
module epoch_ms_to_local_calendar_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ecal_pkg::*;

    localparam longint I64_MAX = {1'b0, {63{1'b1}}};
    localparam longint I64_MIN = {1'b1, 63'b0};
    localparam longint MS_PER_DAY = 86400000;
    localparam longint LAST_DAY = 2932896;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam logic [APB_AW-1:0] ADDR_TZ_OFFSET = '0;

    typedef struct packed {
        t_status                 status;
        logic [YEAR_W-1:0]       year;
        logic [MONTH_W-1:0]      month;
        logic [DAY_W-1:0]        day;
        logic [HOUR_W-1:0]       hour;
        logic [MIN_W-1:0]        minute;
        logic [SEC_W-1:0]        second;
        logic [SLEEP_W-1:0]      sleep_num;
        logic                    sleep_ok;
        logic [SLEEP_MIN_W-1:0]  sleep_minute;
    } t_cal_word;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic [EPOCH_W-1:0]       i_epoch_millis = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [STATUS_W-1:0]      o_status;
    logic [YEAR_W-1:0]        o_year_out;
    logic [MONTH_W-1:0]       o_month_out;
    logic [DAY_W-1:0]         o_day_out;
    logic [HOUR_W-1:0]        o_hour_out;
    logic [MIN_W-1:0]         o_minute_out;
    logic [SEC_W-1:0]         o_second_out;
    logic [SLEEP_W-1:0]       o_sleep_day_number;
    logic                     o_sleep_day_ok;
    logic [SLEEP_MIN_W-1:0]   o_sleep_minute;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_AW-1:0]        paddr = '0;
    logic [APB_DW-1:0]        pwdata = '0;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;

    logic [EPOCH_W-1:0]       pending_ms[$];
    t_cal_word                calendar_due[$];
    logic signed [TZ_W-1:0]   tz_cfg = '0;
    int unsigned              tx_idle_pct = 0;
    int unsigned              rx_idle_pct = 0;
    int unsigned              hold_req = 0;
    int unsigned              hold_seen = 0;
    int unsigned              hold_left = 0;
    int unsigned              cycle_count = 0;
    int unsigned              words_sent = 0;
    int unsigned              words_checked = 0;
    int unsigned              sleep_ok_seen = 0;
    int unsigned              status_seen[4] = '{0, 0, 0, 0};
    int unsigned              mismatches = 0;

    epoch_ms_to_local_calendar_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_epoch_millis     (i_epoch_millis),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_year_out         (o_year_out),
        .o_month_out        (o_month_out),
        .o_day_out          (o_day_out),
        .o_hour_out         (o_hour_out),
        .o_minute_out       (o_minute_out),
        .o_second_out       (o_second_out),
        .o_sleep_day_number (o_sleep_day_number),
        .o_sleep_day_ok     (o_sleep_day_ok),
        .o_sleep_minute     (o_sleep_minute),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_cal_word local_calendar_of(logic [EPOCH_W-1:0] ms_bits,
                                                    logic signed [TZ_W-1:0] tz);
        t_cal_word r;
        longint epoch, tz_min, off_ms, shifted_ms, secs, days, sod;
        longint z, era, doe, yoe, doy, mp, mon, yr, dom, hr, mi, se, sleep;
        r = '0;
        epoch = ms_bits;
        tz_min = tz;
        if (tz_min < -longint'(MAX_OFFSET_MIN) || tz_min > longint'(MAX_OFFSET_MIN)) begin
            r.status = ST_OVERFLOW;
            return r;
        end
        off_ms = tz_min * longint'(MS_PER_MIN);
        if ((off_ms > 0 && epoch > I64_MAX - off_ms) || (off_ms < 0 && epoch < I64_MIN - off_ms)) begin
            r.status = ST_OVERFLOW;
            return r;
        end
        shifted_ms = epoch + off_ms;
        secs = shifted_ms / 1000;
        if (shifted_ms < 0 && shifted_ms % 1000 != 0) begin
            secs = secs - 1;
        end
        days = secs / 86400;
        sod = secs % 86400;
        if (sod < 0) begin
            sod = sod + 86400;
            days = days - 1;
        end
        if (days < 0 || days > LAST_DAY) begin
            r.status = ST_RANGE;
            return r;
        end
        z = days + 719468;
        era = z / 146097;
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp = (5 * doy + 2) / 153;
        mon = (mp < 10) ? mp + 3 : mp - 9;
        dom = doy - (153 * mp + 2) / 5 + 1;
        yr = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
        if (yr < longint'(FIRST_YEAR)) begin
            r.status = ST_EARLY;
            return r;
        end
        hr = sod / longint'(SEC_PER_HOUR);
        mi = (sod % longint'(SEC_PER_HOUR)) / 60;
        se = sod % 60;
        sleep = (hr >= 12) ? days : days - 1;
        r.status = ST_OK;
        r.year = YEAR_W'(yr);
        r.month = MONTH_W'(mon);
        r.day = DAY_W'(dom);
        r.hour = HOUR_W'(hr);
        r.minute = MIN_W'(mi);
        r.second = SEC_W'(se);
        if (sleep >= 0 && sleep <= longint'(SLEEP_DAY_MAX)) begin
            r.sleep_num = SLEEP_W'(sleep);
            r.sleep_ok = 1'b1;
        end
        r.sleep_minute = SLEEP_MIN_W'((hr >= 12) ? (hr - 12) * 60 + mi : (hr + 12) * 60 + mi);
        return r;
    endfunction

    function automatic logic [EPOCH_W-1:0] random_millis(logic signed [TZ_W-1:0] tz);
        int unsigned pick;
        logic [EPOCH_W-1:0] raw;
        logic [EPOCH_W-1:0] mark;
        longint jitter;
        longint off_ms;
        pick = $urandom_range(99);
        raw = {$urandom, $urandom};
        off_ms = longint'(tz) * longint'(MS_PER_MIN);
        jitter = longint'($urandom_range(400000)) - 200000;
        case ($urandom_range(9))
            0: mark = MS_FIRST_YEAR;
            1: mark = MS_LIMIT;
            2: mark = '0;
            3: mark = 64'd2145873600000;
            4: mark = 64'd2145960000000;
            5: mark = 64'd1582934400000;
            6: mark = 64'd4107542400000;
            7: mark = I64_MAX;
            8: mark = I64_MIN;
            default: mark = MS_FIRST_YEAR + (raw % 64'd8000000) * MS_PER_DAY / 2;
        endcase
        if (pick < 40) begin
            return MS_FIRST_YEAR + raw % 64'd600000000000;
        end else if (pick < 60) begin
            return MS_FIRST_YEAR + raw % (MS_LIMIT - MS_FIRST_YEAR);
        end else if (pick < 78) begin
            return mark - off_ms + jitter;
        end else if (pick < 88) begin
            return raw % MS_FIRST_YEAR;
        end
        return raw;
    endfunction

    function automatic void check_field(string field, int unsigned idx, longint want, longint got);
        if (want != got) begin
            $display("%0t word %0d %s mismatch: expected %0d, got %0d",
                     $time, idx, field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        logic [EPOCH_W-1:0] next_ms;
        logic next_valid;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            next_valid = i_valid;
            next_ms = i_epoch_millis;
            if (i_valid && !o_stall) begin
                calendar_due.push_back(local_calendar_of(i_epoch_millis, tz_cfg));
                words_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid && pending_ms.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                next_ms = pending_ms.pop_front();
                next_valid = 1'b1;
            end
            i_valid <= next_valid;
            i_epoch_millis <= next_ms;
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_cal_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (calendar_due.size() == 0) begin
                $display("%0t unexpected word: status %0d year %0d", $time, o_status, o_year_out);
                mismatches++;
            end else begin
                want = calendar_due.pop_front();
                check_field("status", words_checked, want.status, o_status);
                check_field("year", words_checked, want.year, o_year_out);
                check_field("month", words_checked, want.month, o_month_out);
                check_field("day", words_checked, want.day, o_day_out);
                check_field("hour", words_checked, want.hour, o_hour_out);
                check_field("minute", words_checked, want.minute, o_minute_out);
                check_field("second", words_checked, want.second, o_second_out);
                check_field("sleep_day_number", words_checked, want.sleep_num,
                            o_sleep_day_number);
                check_field("sleep_ok", words_checked, want.sleep_ok, o_sleep_day_ok);
                check_field("sleep_minute", words_checked, want.sleep_minute, o_sleep_minute);
                status_seen[want.status]++;
                if (want.sleep_ok) begin
                    sleep_ok_seen++;
                end
            end
            words_checked++;
        end
    end

    task automatic wait_settled();
        do begin
            @(negedge i_clk);
        end while (pending_ms.size() != 0 || i_valid || calendar_due.size() != 0);
    endtask

    task automatic write_tz_offset(logic signed [TZ_W-1:0] tz);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_TZ_OFFSET;
        pwdata <= APB_DW'(tz);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        tz_cfg = tz;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[TZ_W-1:0] !== tz) begin
            $display("%0t tz offset readback mismatch: expected %0d, got %0d",
                     $time, tz, $signed(prdata[TZ_W-1:0]));
            mismatches++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(logic signed [TZ_W-1:0] tz, int unsigned count,
                             int unsigned tx_pct, int unsigned rx_pct, bit long_hold);
        longint off_ms;
        wait_settled();
        repeat (STAGES + 4) @(posedge i_clk);
        write_tz_offset(tz);
        @(negedge i_clk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        if (long_hold) begin
            hold_req++;
        end
        off_ms = longint'(tz) * longint'(MS_PER_MIN);
        if (off_ms > 0) begin
            pending_ms.push_back(I64_MAX - off_ms);
            pending_ms.push_back(I64_MAX - off_ms + 1);
        end else if (off_ms < 0) begin
            pending_ms.push_back(I64_MIN - off_ms);
            pending_ms.push_back(I64_MIN - off_ms - 1);
        end
        pending_ms.push_back(I64_MAX);
        pending_ms.push_back(I64_MIN);
        repeat (count) pending_ms.push_back(random_millis(tz));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        tx_idle_pct = 33;
        rx_idle_pct = 49;
        pending_ms.push_back(I64_MIN);
        pending_ms.push_back(I64_MAX);
        pending_ms.push_back(64'd0);
        pending_ms.push_back(-64'sd1);
        pending_ms.push_back(-64'sd999);
        pending_ms.push_back(64'd31536000000);
        pending_ms.push_back(MS_FIRST_YEAR - 1);
        pending_ms.push_back(MS_FIRST_YEAR);
        pending_ms.push_back(64'd1577879999999);
        pending_ms.push_back(64'd1577880000000);
        pending_ms.push_back(64'd1582934400000);
        pending_ms.push_back(64'd2145873599999);
        pending_ms.push_back(64'd2145873600000);
        pending_ms.push_back(64'd2145959999999);
        pending_ms.push_back(64'd2145960000000);
        pending_ms.push_back(64'd4107542399999);
        pending_ms.push_back(64'd4107542400000);
        pending_ms.push_back(MS_LIMIT - 1);
        pending_ms.push_back(MS_LIMIT);
        pending_ms.push_back(64'h5555_5555_5555_5555);
        pending_ms.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        pending_ms.push_back(64'd253402257600000);
        run_phase(12'sd1440, 100, 33, 49, 1'b0);
        run_phase(-12'sd1440, 100, 33, 49, 1'b1);
        run_phase(12'sd2047, 20, 49, 33, 1'b0);
        run_phase(TZ_W'(-2048), 15, 49, 33, 1'b0);
        run_phase(-12'sd1441, 10, 49, 33, 1'b0);
        run_phase(12'sd330, 120, 49, 33, 1'b1);
        run_phase(-12'sd480, 120, 0, 0, 1'b0);
        run_phase(TZ_W'(int'($urandom_range(2880)) - 1440), 100, 0, 0, 1'b0);
        run_phase(12'sd0, 30, 0, 0, 1'b0);
        wait_settled();
        repeat (STAGES + 10) @(posedge i_clk);
        if (calendar_due.size() != 0) begin
            $display("%0t %0d expected words never arrived", $time, calendar_due.size());
            mismatches++;
        end
        $display("Covered %0d words over ten offset settings, with long stalls and pauses.",
                 words_sent);
        $display("Status ok %0d, overflow %0d, range %0d, early %0d; sleep day valid %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3], sleep_ok_seen);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
